// ===== rtl/core/gdfo_pkg.sv =====
// ============================================================================
// gdfo_pkg
// Shared types and constants for the depth-first order engine.
// ============================================================================
package gdfo_pkg;

    // Fixed field widths of the ports
    localparam int VERTEX_W = 6;
    localparam int COUNT_W  = 7;

    // Vertex ids on the ports never reach past this many vertices
    localparam int VERTEX_LIMIT = 2 ** VERTEX_W;

    // Parameter defaults
    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_MAX_EDGES    = 256;

    // Reset value of the vertex count register
    localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 7'd4;

    // Command codes
    localparam logic CMD_ADD_EDGE = 1'b0;
    localparam logic CMD_TRAVERSE = 1'b1;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_VTX,
        ST_ADD_LINK,
        ST_WALK_ROOT,
        ST_WALK_LOADV,
        ST_WALK_STEP,
        ST_WALK_EDGE,
        ST_WALK_LOADP,
        ST_WALK_FLUSH
    } gdfo_state_t;

    // Request from the controller to the output stage
    typedef struct packed {
        logic                push;
        logic                flush;
        logic                dropped;
        logic [VERTEX_W-1:0] vertex;
    } gdfo_emit_t;

endpackage

// ===== rtl/core/gdfo_ram.sv =====
// ============================================================================
// gdfo_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while no read is issued.
// ============================================================================
module gdfo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/gdfo_out_stage.sv =====
// ============================================================================
// gdfo_out_stage
// Holds the most recent visited vertex until the next one (or the end of the
// traversal) tells whether it is the last, then passes it to the output
// register.
// ============================================================================
module gdfo_out_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gdfo_pkg::gdfo_emit_t          emit,
    output logic                          emit_ready,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [gdfo_pkg::VERTEX_W-1:0] visited_vertex,
    output logic                          last_of_run,
    output logic                          edges_dropped
);

    logic                          pend_valid_reg;
    logic                          pend_valid_next;
    logic [gdfo_pkg::VERTEX_W-1:0] pend_vertex_reg;
    logic                          pend_drop_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [gdfo_pkg::VERTEX_W-1:0] out_vertex_reg;
    logic                          out_last_reg;
    logic                          out_drop_reg;
    logic                          out_free;
    logic                          move;

    // Output register free when empty or being taken now
    assign out_free   = !out_valid_reg || !out_stall;
    assign emit_ready = !pend_valid_reg || out_free;
    assign move       = pend_valid_reg && out_free && (emit.push || emit.flush);

    // Valid flags
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (emit.push)
        begin
            pend_valid_next = 1'b1;
        end
        else if (move)
        begin
            pend_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (emit.push)
        begin
            pend_vertex_reg <= emit.vertex;
            pend_drop_reg   <= emit.dropped;
        end
        if (move)
        begin
            out_vertex_reg <= pend_vertex_reg;
            out_drop_reg   <= pend_drop_reg;
            out_last_reg   <= emit.flush;
        end
    end

    assign out_valid      = out_valid_reg;
    assign visited_vertex = out_vertex_reg;
    assign last_of_run    = out_last_reg;
    assign edges_dropped  = out_drop_reg;

endmodule

// ===== rtl/core/gdfo_ctrl.sv =====
// ============================================================================
// gdfo_ctrl
// Sequencer for edge appends and the depth-first walk. Keeps the vertex and
// edge tables in two RAMs and updates them read-modify-write.
// Vertex entry: {head, tail, saved cursor, parent}. Edge entry: {target, next}.
// ============================================================================
module gdfo_ctrl #(
    parameter int MAX_VERTICES = gdfo_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = gdfo_pkg::DEF_MAX_EDGES,
    localparam int NV  = (MAX_VERTICES < gdfo_pkg::VERTEX_LIMIT) ?
                         MAX_VERTICES : gdfo_pkg::VERTEX_LIMIT,
    localparam int VW  = $clog2(NV),
    localparam int EW  = $clog2(MAX_EDGES),
    localparam int LW  = $clog2(MAX_EDGES + 1),
    localparam int VXW = 3 * LW + VW,
    localparam int EXW = VW + LW
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_valid,
    input  logic [gdfo_pkg::COUNT_W-1:0]  vertex_count,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          command,
    input  logic [gdfo_pkg::VERTEX_W-1:0] src_vertex,
    input  logic [gdfo_pkg::VERTEX_W-1:0] dst_vertex,
    // vertex RAM
    output logic                          vwr_en,
    output logic [VW-1:0]                 vwr_addr,
    output logic [VXW-1:0]                vwr_data,
    output logic                          vrd_en,
    output logic [VW-1:0]                 vrd_addr,
    input  logic [VXW-1:0]                vrd_data,
    // edge RAM
    output logic                          ewr_en,
    output logic [EW-1:0]                 ewr_addr,
    output logic [EXW-1:0]                ewr_data,
    output logic                          erd_en,
    output logic [EW-1:0]                 erd_addr,
    input  logic [EXW-1:0]                erd_data,
    // output stage
    output gdfo_pkg::gdfo_emit_t          emit,
    input  logic                          emit_ready
);

    localparam int NW = $clog2(NV + 1);
    localparam logic [LW-1:0] NULL_LINK = LW'(MAX_EDGES);

    gdfo_pkg::gdfo_state_t state_reg;
    gdfo_pkg::gdfo_state_t state_next;

    logic [gdfo_pkg::COUNT_W-1:0] vcount_reg;
    logic [LW-1:0]                edges_used_reg;
    logic [LW-1:0]                edges_used_next;
    logic                         drop_reg;
    logic                         drop_next;
    logic [NV-1:0]                nonempty_reg;
    logic [NV-1:0]                nonempty_next;
    logic [NV-1:0]                visited_reg;
    logic [NV-1:0]                visited_next;
    logic [NW-1:0]                root_reg;
    logic [NW-1:0]                root_next;

    logic [VW-1:0]                src_reg;
    logic [VW-1:0]                dst_reg;
    logic [VW-1:0]                cur_reg;
    logic [VW-1:0]                cur_next;
    logic [LW-1:0]                cursor_reg;
    logic [LW-1:0]                cursor_next;
    logic [LW-1:0]                top_head_reg;
    logic [LW-1:0]                top_head_next;
    logic [LW-1:0]                top_tail_reg;
    logic [LW-1:0]                top_tail_next;
    logic [VW-1:0]                top_parent_reg;
    logic [VW-1:0]                top_parent_next;
    logic [LW-1:0]                link_reg;

    logic [NW-1:0]                n_eff;
    logic                         accept;
    logic                         add_ok;
    logic [VW-1:0]                root_idx;
    logic                         root_live;
    logic                         root_push;
    logic                         cur_done;
    logic                         at_root;
    logic                         edge_cand;
    logic                         edge_push;
    logic [VW-1:0]                push_idx;

    logic [LW-1:0]                vrd_head;
    logic [LW-1:0]                vrd_tail;
    logic [LW-1:0]                vrd_cursor;
    logic [VW-1:0]                vrd_parent;
    logic [VW-1:0]                erd_target;
    logic [LW-1:0]                erd_next;

    // RAM entry fields
    assign vrd_head   = vrd_data[VXW-1 -: LW];
    assign vrd_tail   = vrd_data[VXW-1-LW -: LW];
    assign vrd_cursor = vrd_data[VW +: LW];
    assign vrd_parent = vrd_data[VW-1:0];
    assign erd_target = erd_data[EXW-1 -: VW];
    assign erd_next   = erd_data[LW-1:0];

    // Vertex count in use, limited to the table size
    assign n_eff = (vcount_reg > gdfo_pkg::COUNT_W'(NV)) ? NW'(NV) : vcount_reg[NW-1:0];

    // Decode
    assign accept    = in_valid && (state_reg == gdfo_pkg::ST_IDLE);
    assign add_ok    = (gdfo_pkg::COUNT_W'(src_vertex) < gdfo_pkg::COUNT_W'(n_eff))
                    && (gdfo_pkg::COUNT_W'(dst_vertex) < gdfo_pkg::COUNT_W'(n_eff))
                    && (edges_used_reg != NULL_LINK);
    assign root_idx  = root_reg[VW-1:0];
    assign root_live = root_reg < n_eff;
    assign root_push = (state_reg == gdfo_pkg::ST_WALK_ROOT) && root_live
                    && !visited_reg[root_idx] && emit_ready;
    assign cur_done  = cursor_reg == NULL_LINK;
    assign at_root   = cur_reg == root_idx;
    assign edge_cand = (NW'(erd_target) < n_eff) && !visited_reg[erd_target];
    assign edge_push = (state_reg == gdfo_pkg::ST_WALK_EDGE) && edge_cand && emit_ready;
    assign push_idx  = (state_reg == gdfo_pkg::ST_WALK_ROOT) ? root_idx : erd_target;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gdfo_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (command == gdfo_pkg::CMD_TRAVERSE)
                    begin
                        state_next = gdfo_pkg::ST_WALK_ROOT;
                    end
                    else if (add_ok)
                    begin
                        state_next = gdfo_pkg::ST_ADD_VTX;
                    end
                end
            end
            gdfo_pkg::ST_ADD_VTX:
            begin
                state_next = nonempty_reg[src_reg] ? gdfo_pkg::ST_ADD_LINK : gdfo_pkg::ST_IDLE;
            end
            gdfo_pkg::ST_ADD_LINK:
            begin
                state_next = gdfo_pkg::ST_IDLE;
            end
            gdfo_pkg::ST_WALK_ROOT:
            begin
                if (!root_live)
                begin
                    state_next = gdfo_pkg::ST_WALK_FLUSH;
                end
                else if (root_push)
                begin
                    state_next = gdfo_pkg::ST_WALK_LOADV;
                end
            end
            gdfo_pkg::ST_WALK_LOADV:
            begin
                state_next = gdfo_pkg::ST_WALK_STEP;
            end
            gdfo_pkg::ST_WALK_LOADP:
            begin
                state_next = gdfo_pkg::ST_WALK_STEP;
            end
            gdfo_pkg::ST_WALK_STEP:
            begin
                if (!cur_done)
                begin
                    state_next = gdfo_pkg::ST_WALK_EDGE;
                end
                else if (at_root)
                begin
                    state_next = gdfo_pkg::ST_WALK_ROOT;
                end
                else
                begin
                    state_next = gdfo_pkg::ST_WALK_LOADP;
                end
            end
            gdfo_pkg::ST_WALK_EDGE:
            begin
                if (!edge_cand)
                begin
                    state_next = gdfo_pkg::ST_WALK_STEP;
                end
                else if (edge_push)
                begin
                    state_next = gdfo_pkg::ST_WALK_LOADV;
                end
            end
            gdfo_pkg::ST_WALK_FLUSH:
            begin
                if (emit_ready)
                begin
                    state_next = gdfo_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gdfo_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs: RAM ports, emit request, input stall
    always_comb
    begin
        in_stall     = state_reg != gdfo_pkg::ST_IDLE;
        vwr_en       = 1'b0;
        vwr_addr     = cur_reg;
        vwr_data     = {top_head_reg, top_tail_reg, erd_next, top_parent_reg};
        vrd_en       = 1'b0;
        vrd_addr     = src_vertex[VW-1:0];
        ewr_en       = 1'b0;
        ewr_addr     = edges_used_reg[EW-1:0];
        ewr_data     = {dst_reg, NULL_LINK};
        erd_en       = 1'b0;
        erd_addr     = cursor_reg[EW-1:0];
        emit.push    = root_push || edge_push;
        emit.flush   = state_reg == gdfo_pkg::ST_WALK_FLUSH;
        emit.dropped = drop_reg;
        emit.vertex  = gdfo_pkg::VERTEX_W'(push_idx);
        case (state_reg)
            gdfo_pkg::ST_IDLE:
            begin
                // fetch the source entry of a valid edge
                vrd_en = accept && (command == gdfo_pkg::CMD_ADD_EDGE) && add_ok;
            end
            gdfo_pkg::ST_ADD_VTX:
            begin
                // update source entry, store new edge, fetch old tail edge
                vwr_en   = 1'b1;
                vwr_addr = src_reg;
                vwr_data = {nonempty_reg[src_reg] ? vrd_head : edges_used_reg,
                            edges_used_reg, vrd_cursor, vrd_parent};
                ewr_en   = 1'b1;
                erd_en   = nonempty_reg[src_reg];
                erd_addr = vrd_tail[EW-1:0];
            end
            gdfo_pkg::ST_ADD_LINK:
            begin
                // chain old tail to the new edge
                ewr_en   = 1'b1;
                ewr_addr = top_tail_reg[EW-1:0];
                ewr_data = {erd_target, link_reg};
            end
            gdfo_pkg::ST_WALK_ROOT:
            begin
                vrd_en   = root_push;
                vrd_addr = root_idx;
            end
            gdfo_pkg::ST_WALK_STEP:
            begin
                erd_en   = !cur_done;
                vrd_en   = cur_done && !at_root;
                vrd_addr = top_parent_reg;
            end
            gdfo_pkg::ST_WALK_EDGE:
            begin
                // descend: save our frame, fetch the child entry
                vwr_en   = edge_push;
                vrd_en   = edge_push;
                vrd_addr = erd_target;
            end
            default:
            begin
                vwr_en = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        edges_used_next = edges_used_reg;
        drop_next       = drop_reg;
        nonempty_next   = nonempty_reg;
        visited_next    = visited_reg;
        root_next       = root_reg;
        cur_next        = cur_reg;
        cursor_next     = cursor_reg;
        top_head_next   = top_head_reg;
        top_tail_next   = top_tail_reg;
        top_parent_next = top_parent_reg;
        case (state_reg)
            gdfo_pkg::ST_IDLE:
            begin
                if (accept && (command == gdfo_pkg::CMD_TRAVERSE))
                begin
                    visited_next = '0;
                    root_next    = '0;
                end
                else if (accept && !add_ok)
                begin
                    drop_next = 1'b1;
                end
            end
            gdfo_pkg::ST_ADD_VTX:
            begin
                nonempty_next[src_reg] = 1'b1;
                edges_used_next        = edges_used_reg + LW'(1);
                top_tail_next          = vrd_tail;
            end
            gdfo_pkg::ST_WALK_ROOT:
            begin
                if (root_push)
                begin
                    visited_next[root_idx] = 1'b1;
                    cur_next               = root_idx;
                    top_parent_next        = root_idx;
                end
                else if (root_live)
                begin
                    root_next = visited_reg[root_idx] ? root_reg + NW'(1) : root_reg;
                end
            end
            gdfo_pkg::ST_WALK_LOADV:
            begin
                top_head_next = vrd_head;
                top_tail_next = vrd_tail;
                cursor_next   = nonempty_reg[cur_reg] ? vrd_head : NULL_LINK;
            end
            gdfo_pkg::ST_WALK_LOADP:
            begin
                top_head_next   = vrd_head;
                top_tail_next   = vrd_tail;
                top_parent_next = vrd_parent;
                cursor_next     = vrd_cursor;
            end
            gdfo_pkg::ST_WALK_STEP:
            begin
                if (cur_done && at_root)
                begin
                    root_next = root_reg + NW'(1);
                end
                else if (cur_done)
                begin
                    cur_next = top_parent_reg;
                end
            end
            gdfo_pkg::ST_WALK_EDGE:
            begin
                if (!edge_cand)
                begin
                    cursor_next = erd_next;
                end
                else if (edge_push)
                begin
                    visited_next[erd_target] = 1'b1;
                    top_parent_next          = cur_reg;
                    cur_next                 = erd_target;
                end
            end
            default:
            begin
                drop_next = drop_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= gdfo_pkg::ST_IDLE;
            vcount_reg     <= gdfo_pkg::VERTEX_COUNT_RESET;
            edges_used_reg <= '0;
            drop_reg       <= 1'b0;
            nonempty_reg   <= '0;
            visited_reg    <= '0;
            root_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            edges_used_reg <= edges_used_next;
            drop_reg       <= drop_next;
            nonempty_reg   <= nonempty_next;
            visited_reg    <= visited_next;
            root_reg       <= root_next;
            if (cfg_valid)
            begin
                vcount_reg <= vertex_count;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            src_reg <= src_vertex[VW-1:0];
            dst_reg <= dst_vertex[VW-1:0];
        end
        if (state_reg == gdfo_pkg::ST_ADD_VTX)
        begin
            link_reg <= edges_used_reg;
        end
        cur_reg        <= cur_next;
        cursor_reg     <= cursor_next;
        top_head_reg   <= top_head_next;
        top_tail_reg   <= top_tail_next;
        top_parent_reg <= top_parent_next;
    end

    // Checks
    a_edges_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        edges_used_reg <= NULL_LINK)
        else $error("edge count beyond store size");

    a_drop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        drop_reg |=> drop_reg)
        else $error("drop flag cleared");

    a_visit_once: assert property (@(posedge clk) disable iff (!rst_n)
        emit.push |-> !visited_reg[push_idx])
        else $error("vertex emitted twice in one traversal");

    a_cursor_written: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gdfo_pkg::ST_WALK_STEP && !cur_done) |-> cursor_reg < edges_used_reg)
        else $error("walk cursor points at an unwritten edge");

    a_edge_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (ewr_en && erd_en) |-> ewr_addr != erd_addr)
        else $error("edge RAM read and write hit one entry");

endmodule

// ===== rtl/core/graph_depth_first_order.sv =====
// ============================================================================
// graph_depth_first_order
// Directed graph builder with full depth-first preorder traversal.
// ============================================================================
// An add-edge transaction appends the destination to the source vertex's
// neighbor list: the source entry is read, then updated with the new edge
// stored, and when the source already has edges the old tail edge is read
// and relinked; a dropped edge only sets the sticky drop flag. A traverse
// transaction walks every vertex below the vertex count (limited to
// MAX_VERTICES and 64) and delivers one result per vertex in preorder,
// last_of_run marking the final one. The walk checks each root candidate,
// reads each stored edge examined, loads the entry of each vertex entered
// and of the parent on each return, and ends with the final root check and
// the flush of the last result; output stalls hold it. Its pace is set by
// the single read port of the vertex and edge RAMs, each with registered
// read data. Per-vertex occupancy and visited flags sit in flip-flops
// cleared at reset, so no clearing pass is needed. The input stalls until
// a transaction is finished.
// ============================================================================
module graph_depth_first_order #(
    parameter int MAX_VERTICES = gdfo_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = gdfo_pkg::DEF_MAX_EDGES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gdfo_pkg::COUNT_W-1:0]  vertex_count,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          command,
    input  logic [gdfo_pkg::VERTEX_W-1:0] src_vertex,
    input  logic [gdfo_pkg::VERTEX_W-1:0] dst_vertex,
    // output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [gdfo_pkg::VERTEX_W-1:0] visited_vertex,
    output logic                          last_of_run,
    output logic                          edges_dropped
);

    localparam int NV  = (MAX_VERTICES < gdfo_pkg::VERTEX_LIMIT) ?
                         MAX_VERTICES : gdfo_pkg::VERTEX_LIMIT;
    localparam int VW  = $clog2(NV);
    localparam int EW  = $clog2(MAX_EDGES);
    localparam int LW  = $clog2(MAX_EDGES + 1);
    localparam int VXW = 3 * LW + VW;
    localparam int EXW = VW + LW;

    logic                 vwr_en;
    logic [VW-1:0]        vwr_addr;
    logic [VXW-1:0]       vwr_data;
    logic                 vrd_en;
    logic [VW-1:0]        vrd_addr;
    logic [VXW-1:0]       vrd_data;
    logic                 ewr_en;
    logic [EW-1:0]        ewr_addr;
    logic [EXW-1:0]       ewr_data;
    logic                 erd_en;
    logic [EW-1:0]        erd_addr;
    logic [EXW-1:0]       erd_data;
    gdfo_pkg::gdfo_emit_t emit;
    logic                 emit_ready;

    // Configuration is taken at any time
    assign cfg_ready = 1'b1;

    // Controller
    gdfo_ctrl #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .vertex_count (vertex_count),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .src_vertex   (src_vertex),
        .dst_vertex   (dst_vertex),
        .vwr_en       (vwr_en),
        .vwr_addr     (vwr_addr),
        .vwr_data     (vwr_data),
        .vrd_en       (vrd_en),
        .vrd_addr     (vrd_addr),
        .vrd_data     (vrd_data),
        .ewr_en       (ewr_en),
        .ewr_addr     (ewr_addr),
        .ewr_data     (ewr_data),
        .erd_en       (erd_en),
        .erd_addr     (erd_addr),
        .erd_data     (erd_data),
        .emit         (emit),
        .emit_ready   (emit_ready)
    );

    // Vertex table: head, tail, saved cursor, parent
    gdfo_ram #(
        .WIDTH (VXW),
        .DEPTH (NV)
    ) u_vertex_ram (
        .clk     (clk),
        .wr_en   (vwr_en),
        .wr_addr (vwr_addr),
        .wr_data (vwr_data),
        .rd_en   (vrd_en),
        .rd_addr (vrd_addr),
        .rd_data (vrd_data)
    );

    // Edge store: target, next link
    gdfo_ram #(
        .WIDTH (EXW),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .clk     (clk),
        .wr_en   (ewr_en),
        .wr_addr (ewr_addr),
        .wr_data (ewr_data),
        .rd_en   (erd_en),
        .rd_addr (erd_addr),
        .rd_data (erd_data)
    );

    // Result staging and output register
    gdfo_out_stage u_out_stage (
        .clk            (clk),
        .rst_n          (rst_n),
        .emit           (emit),
        .emit_ready     (emit_ready),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .visited_vertex (visited_vertex),
        .last_of_run    (last_of_run),
        .edges_dropped  (edges_dropped)
    );

endmodule

// ===== sim/graph_depth_first_order_tb.sv =====
// ============================================================================
// graph_depth_first_order_tb
// Self-checking bench for the depth-first order engine.
// ============================================================================
// Edge and traverse transactions go in over the input channel. A behavioral
// copy of the adjacency lists predicts the preorder that each traversal
// yields, and every output transaction is checked against the oldest
// prediction. Directed tests cover reset count, list order, dropped edges
// and count extremes. Random phases then build graphs under several vertex
// counts. The input idles and the output stalls at random.
// ============================================================================
module graph_depth_first_order_tb;

    localparam int MAX_V         = gdfo_pkg::DEF_MAX_VERTICES;
    localparam int MAX_E         = gdfo_pkg::DEF_MAX_EDGES;
    localparam int NULL_LINK     = MAX_E;
    localparam int SETTLE_CYCLES = 8;
    // Watchdog limit: a wide margin over the longest gap between results of a
    // traversal with a full store, even with the longest stall.
    localparam int IDLE_LIMIT    = 20000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 20;

    typedef struct packed {
        logic [gdfo_pkg::VERTEX_W-1:0] vertex;
        logic                          last;
        logic                          dropped;
    } visit_t;

    logic                          clk;
    logic                          rst_n        = 1'b0;
    logic                          cfg_valid    = 1'b0;
    logic                          cfg_ready;
    logic [gdfo_pkg::COUNT_W-1:0]  vertex_count = gdfo_pkg::VERTEX_COUNT_RESET;
    logic                          in_valid     = 1'b0;
    logic                          in_stall;
    logic                          command      = gdfo_pkg::CMD_ADD_EDGE;
    logic [gdfo_pkg::VERTEX_W-1:0] src_vertex   = '0;
    logic [gdfo_pkg::VERTEX_W-1:0] dst_vertex   = '0;
    logic                          out_valid;
    logic                          out_stall    = 1'b0;
    logic [gdfo_pkg::VERTEX_W-1:0] visited_vertex;
    logic                          last_of_run;
    logic                          edges_dropped;

    // Behavioral copy of the graph store
    logic [gdfo_pkg::COUNT_W-1:0]  count_shadow;
    int                            list_first [MAX_V];
    int                            list_last  [MAX_V];
    int                            edge_dst   [MAX_E];
    int                            edge_link  [MAX_E];
    int                            edges_stored;
    logic                          drop_seen;

    visit_t                        pending_visits [$];
    int                            error_count;
    bit                            quiet;
    int                            stall_left;
    int                            idle_cycles;

    graph_depth_first_order u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .vertex_count   (vertex_count),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .src_vertex     (src_vertex),
        .dst_vertex     (dst_vertex),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .visited_vertex (visited_vertex),
        .last_of_run    (last_of_run),
        .edges_dropped  (edges_dropped)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14)
            return $urandom_range(0, 2);
        else if (r < 18)
            return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    function automatic int active_vertices();
        return (count_shadow > MAX_V) ? MAX_V : int'(count_shadow);
    endfunction

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    task automatic append_edge(input int s, input int d);
        int n;
        int e;
        n = active_vertices();
        if (s >= n || d >= n || edges_stored >= MAX_E)
        begin
            drop_seen = 1'b1;
            return;
        end
        e = edges_stored;
        edges_stored++;
        edge_dst[e]  = d;
        edge_link[e] = NULL_LINK;
        if (list_first[s] == NULL_LINK || list_last[s] == NULL_LINK)
            list_first[s] = e;
        else
            edge_link[list_last[s]] = e;
        list_last[s] = e;
    endtask

    // Full preorder walk with an explicit stack of cursor frames
    task automatic predict_walk();
        int     n;
        int     sp;
        int     c;
        int     t;
        int     frame_cur [MAX_V];
        bit     seen      [MAX_V];
        visit_t order     [$];
        visit_t v;
        n = active_vertices();
        foreach (seen[i])
            seen[i] = 1'b0;
        for (int r = 0; r < n; r++)
        begin
            if (seen[r])
                continue;
            seen[r]   = 1'b1;
            v.vertex  = r[gdfo_pkg::VERTEX_W-1:0];
            v.last    = 1'b0;
            v.dropped = drop_seen;
            order     = {order, v};
            frame_cur[0] = list_first[r];
            sp = 1;
            while (sp > 0)
            begin
                c = frame_cur[sp-1];
                if (c >= NULL_LINK)
                begin
                    sp--;
                    continue;
                end
                frame_cur[sp-1] = edge_link[c];
                t = edge_dst[c];
                if (t < n && !seen[t] && sp < MAX_V)
                begin
                    seen[t]   = 1'b1;
                    v.vertex  = t[gdfo_pkg::VERTEX_W-1:0];
                    order     = {order, v};
                    frame_cur[sp] = list_first[t];
                    sp++;
                end
            end
        end
        if (order.size() > 0)
            order[order.size()-1].last = 1'b1;
        foreach (order[i])
            pending_visits = {pending_visits, order[i]};
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_item(input logic cmd, input logic [gdfo_pkg::VERTEX_W-1:0] s,
                             input logic [gdfo_pkg::VERTEX_W-1:0] d);
        int gap;
        gap = quiet ? 0 : ($urandom_range(0, 1) ? pick_gap() : 0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        src_vertex <= s;
        dst_vertex <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (cmd == gdfo_pkg::CMD_ADD_EDGE)
            append_edge(int'(s), int'(d));
        else
            predict_walk();
    endtask

    task automatic add_edge(input int s, input int d);
        send_item(gdfo_pkg::CMD_ADD_EDGE, s[gdfo_pkg::VERTEX_W-1:0],
                  d[gdfo_pkg::VERTEX_W-1:0]);
    endtask

    task automatic traverse();
        send_item(gdfo_pkg::CMD_TRAVERSE, gdfo_pkg::VERTEX_W'($urandom),
                  gdfo_pkg::VERTEX_W'($urandom));
    endtask

    // Let every expected visit arrive and any edge update finish
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_visits.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_vertex_count(input logic [gdfo_pkg::COUNT_W-1:0] value);
        wait_idle();
        cfg_valid    <= 1'b1;
        vertex_count <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid    <= 1'b0;
        count_shadow  = value;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty graph under the reset count: every vertex is its own root
    task automatic test_empty_graph_at_reset();
        traverse();
        wait_idle();
    endtask

    // Insertion order, back edges, self loop and a repeated edge
    task automatic test_preorder_basic();
        add_edge(0, 2);
        add_edge(0, 1);
        add_edge(2, 3);
        add_edge(1, 0);
        add_edge(3, 3);
        add_edge(0, 2);
        traverse();
        wait_idle();
    endtask

    // Out-of-range source and destination set the sticky flag
    task automatic test_dropped_edges();
        add_edge(4, 0);
        add_edge(0, 63);
        add_edge(63, 63);
        traverse();
        wait_idle();
    endtask

    // Zero, one, all-ones and full counts, then a lowered count
    task automatic test_count_extremes();
        write_vertex_count(7'd0);
        add_edge(0, 0);
        traverse();
        write_vertex_count(7'd1);
        traverse();
        write_vertex_count(7'd127);
        add_edge(63, 0);
        add_edge(0, 63);
        traverse();
        write_vertex_count(7'd64);
        traverse();
        write_vertex_count(7'd2);
        traverse();
        wait_idle();
    endtask

    // Graphs grow under a changing count; mostly in-range edges
    task automatic test_random_phases();
        int sel;
        int n;
        int r;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
                write_vertex_count(7'd0);
            else if (sel == 1)
                write_vertex_count($urandom_range(0, 1) ? 7'd127 : 7'd64);
            else
                write_vertex_count(7'($urandom_range(1, 16)));
            quiet = ($urandom_range(0, 3) == 0);
            n = (count_shadow == 0) ? 1 : active_vertices();
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    traverse();
                else if (r < 18)
                    send_item(gdfo_pkg::CMD_ADD_EDGE, gdfo_pkg::VERTEX_W'($urandom),
                              gdfo_pkg::VERTEX_W'($urandom));
                else
                    add_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1));
            end
            traverse();
            wait_idle();
        end
        quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Output stall pattern
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (rst_n && !quiet && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // Result check
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        visit_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_visits.size() == 0)
            begin
                report_mismatch("unexpected visit, vertex", visited_vertex, -1);
            end
            else
            begin
                want = pending_visits.pop_front();
                if (visited_vertex !== want.vertex)
                    report_mismatch("visited_vertex", visited_vertex, want.vertex);
                if (last_of_run !== want.last)
                    report_mismatch("last_of_run", last_of_run, want.last);
                if (edges_dropped !== want.dropped)
                    report_mismatch("edges_dropped", edges_dropped, want.dropped);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles with no transaction on any channel
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("ERROR %0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        count_shadow = gdfo_pkg::VERTEX_COUNT_RESET;
        foreach (list_first[i])
        begin
            list_first[i] = NULL_LINK;
            list_last[i]  = NULL_LINK;
        end
        foreach (edge_dst[i])
        begin
            edge_dst[i]  = 0;
            edge_link[i] = 0;
        end
        edges_stored = 0;
        drop_seen    = 1'b0;
        error_count  = 0;
        quiet        = 1'b0;
        stall_left   = 0;
        idle_cycles  = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_graph_at_reset();
        test_preorder_basic();
        test_dropped_edges();
        test_count_extremes();
        test_random_phases();
        wait_idle();

        if (pending_visits.size() != 0)
            report_mismatch("visits never delivered", 0, pending_visits.size());
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
